>>> rtl/irkem_pkg.sv
// Shared types, codes and the constant scan-code to key-code table.
`timescale 1ns / 1ps
`default_nettype none

package irkem_pkg;

  // Table geometry and field widths
  localparam int unsigned KEY_COUNT  = 36;
  localparam int unsigned SCAN_W     = 32;
  localparam int unsigned KEY_W      = 9;
  localparam int unsigned DELAY_W    = 16;
  localparam int unsigned HOLD_W     = 2;

  // Release delay after reset, in milliseconds
  localparam logic [DELAY_W-1:0] RELEASE_DELAY_RST = 16'd200;

  // Hold counter limits
  localparam logic [HOLD_W-1:0] HOLD_FIRST    = 2'd1;
  localparam logic [HOLD_W-1:0] HOLD_FIRST_RP = 2'd2;
  localparam logic [HOLD_W-1:0] HOLD_MAX      = 2'd3;

  // Input command codes
  localparam logic CMD_FRAME = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // Event kinds on the result side
  typedef enum logic [1:0] {
    ACT_PRESS   = 2'd0,
    ACT_REPEAT  = 2'd1,
    ACT_RELEASE = 2'd2
  } key_action_e;

  // Outcome of one table match
  typedef struct packed {
    logic             hit;
    logic [KEY_W-1:0] key;
  } lookup_t;

  // Scan codes; the first matching slot wins
  localparam logic [SCAN_W-1:0] KEY_SCAN [KEY_COUNT] = '{
    32'heb14ff00, 32'hffffffff, 32'hffffffff, 32'hb946ff00,
    32'hf609ff00, 32'he21dff00, 32'he01fff00, 32'hf20dff00,
    32'he619ff00, 32'he41bff00, 32'hee11ff00, 32'hea15ff00,
    32'he817ff00, 32'hed12ff00, 32'hffffffff, 32'hf708ff00,
    32'haf50ff00, 32'hffffffff, 32'hb748ff00, 32'hffffffff,
    32'hffffffff, 32'hf906ff00, 32'hffffffff, 32'hfc03ff00,
    32'hb847ff00, 32'hf807ff00, 32'hbf40ff00, 32'hffffffff,
    32'he718ff00, 32'hbb44ff00, 32'hffffffff, 32'hae51ff00,
    32'hf50aff00, 32'he11eff00, 32'hf10eff00, 32'he51aff00
  };

  // Key codes for each slot; zero marks an unused slot
  localparam logic [KEY_W-1:0] KEY_NUM [KEY_COUNT] = '{
    9'd116, 9'd0,   9'd0,   9'd113,
    9'd59,  9'd60,  9'd61,  9'd388,
    9'd62,  9'd63,  9'd372, 9'd64,
    9'd65,  9'd139, 9'd0,   9'd158,
    9'd66,  9'd0,   9'd67,  9'd0,
    9'd0,   9'd103, 9'd0,   9'd12,
    9'd105, 9'd28,  9'd106, 9'd0,
    9'd174, 9'd108, 9'd0,   9'd12,
    9'd164, 9'd128, 9'd168, 9'd159
  };

endpackage

`default_nettype wire

>>> rtl/ir_remote_key_event_mapper.sv
// Top level: IR frame and tick beats in, press, repeat and release key events out.
`timescale 1ns / 1ps
`default_nettype none

// Each input beat is either a decoded IR frame (tuser[0] low) or a one
// millisecond tick (tuser[0] high). A frame whose scan code is in the key
// table yields a press, or a repeat when the decoder flagged it so, and
// rearms the release countdown from cfg_data_i (last written value, 200
// after reset); a tick that runs the countdown out yields a release. Not
// every beat yields an event. The block takes one beat per clock cycle;
// an event is offered on the master side from the result register, after
// its beat has passed the input register and the single table match.
// Backpressure on the master side stalls the input only once both
// registers are full.
module ir_remote_key_event_mapper (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration: release delay in milliseconds
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i,
  // Input beats
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] frame_word
  input  wire logic [1:0]  s_axis_tuser,   // [0] command, [1] repeat_status
  // Event beats
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [8:0] key number, [15:9] zero
  output logic [1:0]       m_axis_tuser    // [1:0] key_action
);

  localparam int unsigned SW = irkem_pkg::SCAN_W;
  localparam int unsigned KW = irkem_pkg::KEY_W;
  localparam int unsigned DW = irkem_pkg::DELAY_W;
  localparam int unsigned HW = irkem_pkg::HOLD_W;

  // Configuration register
  logic [DW-1:0] delay_q;

  // Input register
  logic          in_valid_q;
  logic          in_cmd_q;
  logic          in_rep_q;
  logic [SW-1:0] in_word_q;

  // Mapper state
  logic [SW-1:0] last_scan_q, last_scan_d;
  logic [HW-1:0] hold_q, hold_d;
  logic [KW-1:0] cur_key_q, cur_key_d;
  logic [DW-1:0] count_q, count_d;
  logic          armed_q, armed_d;

  // Result register
  logic                    out_valid_q;
  logic [KW-1:0]           out_key_q;
  irkem_pkg::key_action_e  out_act_q;

  logic                    advance;
  logic                    in_ready;
  logic                    emit;
  logic [KW-1:0]           emit_key;
  irkem_pkg::key_action_e  emit_act;
  logic [SW-1:0]           scan;
  irkem_pkg::lookup_t      lookup;

  // Handshakes: the result register frees when empty or taken
  assign advance       = !out_valid_q || m_axis_tready;
  assign in_ready      = !in_valid_q || advance;
  assign s_axis_tready = in_ready;
  assign cfg_ready_o   = 1'b1;

  // Hold the release delay
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= irkem_pkg::RELEASE_DELAY_RST;
    end else if (cfg_valid_i) begin
      delay_q <= cfg_data_i;
    end
  end

  // Capture the input beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && in_ready) begin
      in_word_q <= s_axis_tdata;
      in_cmd_q  <= s_axis_tuser[0];
      in_rep_q  <= s_axis_tuser[1];
    end
  end

  // Hold counter and the scan code that an empty repeat frame stands for
  always_comb begin
    if (in_word_q != '0) begin
      hold_d = irkem_pkg::HOLD_FIRST;
    end else if (hold_q != irkem_pkg::HOLD_MAX) begin
      hold_d = hold_q + HW'(1);
    end else begin
      hold_d = hold_q;
    end
    if (in_word_q == '0 && in_rep_q && hold_d != irkem_pkg::HOLD_FIRST_RP) begin
      scan = last_scan_q;
    end else begin
      scan = in_word_q;
    end
  end

  irkem_rom_match u_match (
    .scan_i   (scan),
    .result_o (lookup)
  );

  // Work out the next state and the event for the registered beat
  always_comb begin
    last_scan_d = last_scan_q;
    cur_key_d   = cur_key_q;
    count_d     = count_q;
    armed_d     = armed_q;
    emit        = 1'b0;
    emit_key    = lookup.key;
    emit_act    = in_rep_q ? irkem_pkg::ACT_REPEAT : irkem_pkg::ACT_PRESS;
    if (in_cmd_q == irkem_pkg::CMD_TICK) begin
      emit_key = cur_key_q;
      emit_act = irkem_pkg::ACT_RELEASE;
      if (armed_q) begin
        if (count_q > DW'(1)) begin
          count_d = count_q - DW'(1);
        end else begin
          // Countdown ran out: disarm and release unless the slot is unused
          count_d = '0;
          armed_d = 1'b0;
          emit    = (cur_key_q != '0);
        end
      end
    end else if (lookup.hit) begin
      last_scan_d = scan;
      cur_key_d   = lookup.key;
      count_d     = delay_q;
      armed_d     = 1'b1;
      emit        = (lookup.key != '0);
    end
  end

  // Advance mapper state when the beat leaves the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_scan_q <= '0;
      hold_q      <= '0;
      cur_key_q   <= '0;
      count_q     <= '0;
      armed_q     <= 1'b0;
    end else if (in_valid_q && advance) begin
      last_scan_q <= last_scan_d;
      cur_key_q   <= cur_key_d;
      count_q     <= count_d;
      armed_q     <= armed_d;
      if (in_cmd_q == irkem_pkg::CMD_FRAME) begin
        hold_q <= hold_d;
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q && emit) begin
      out_key_q <= emit_key;
      out_act_q <= emit_act;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(16 - KW)'(0), out_key_q};
  assign m_axis_tuser  = out_act_q;

endmodule

`default_nettype wire

>>> rtl/irkem_rom_match.sv
// Parallel match of a scan code against the constant key table.
`timescale 1ns / 1ps
`default_nettype none

module irkem_rom_match (
  input  wire logic [irkem_pkg::SCAN_W-1:0] scan_i,
  output irkem_pkg::lookup_t                result_o
);

  irkem_pkg::lookup_t result;

  // Walk from the last slot down so the lowest matching slot has priority
  always_comb begin
    result.hit = 1'b0;
    result.key = '0;
    for (int i = irkem_pkg::KEY_COUNT - 1; i >= 0; i--) begin
      if (irkem_pkg::KEY_SCAN[i] == scan_i) begin
        result.hit = 1'b1;
        result.key = irkem_pkg::KEY_NUM[i];
      end
    end
  end

  assign result_o = result;

endmodule

`default_nettype wire
